@@ hw/rtl/pcsw_pkg.sv @@
package pcsw_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 2'd2;

    // Event commands
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int ENG_W      = 8;
    localparam int STREAK_W   = 3;
    localparam int CHIP_W     = 4;
    localparam int OUT_CHIP_W = 3;
    localparam int COUNT_W    = 4;
    localparam int MASK_W     = 8;
    localparam int DIVD_W     = 11;

    // Chips that own an enable bit
    localparam int ENABLE_CHIPS = 8;

    // Base timeout scaled by 32 (15 s or 60 s)
    localparam logic [DIVD_W-1:0] SHORT_LIMIT = 11'(15 * 32);
    localparam logic [DIVD_W-1:0] LONG_LIMIT  = 11'(60 * 32);

    localparam logic [STREAK_W-1:0] MAX_STREAK = 3'd5;
    localparam logic [TIME_W-1:0]   IDLE_GRACE = 32'd10;

    localparam logic [COUNT_W-1:0] RESET_CHIP_COUNT = 4'd8;
    localparam logic [MASK_W-1:0]  RESET_MASK       = 8'hFF;

    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [ENG_W-1:0]    eng;
        logic                seen;
        logic [STREAK_W-1:0] streak;
        logic                dead;
    } t_rec;

    typedef struct packed {
        logic                  reset_needed;
        logic [OUT_CHIP_W-1:0] stalled_chip;
        logic                  chip_died;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EVAL,
        S_DIV,
        S_CMP,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/pcsw_req_if.sv @@
interface pcsw_req_if import pcsw_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CHIP_W-1:0] chip;
    logic [ENG_W-1:0]  engines;
    logic [TIME_W-1:0] now;
    logic              idle;

    modport source (output valid, output cmd, output chip, output engines,
                    output now, output idle, input ready);
    modport sink   (input valid, input cmd, input chip, input engines,
                    input now, input idle, output ready);
endinterface

@@ hw/rtl/pcsw_rsp_if.sv @@
interface pcsw_rsp_if import pcsw_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic                  reset_needed;
    logic [OUT_CHIP_W-1:0] stalled_chip;
    logic                  chip_died;

    modport source (output valid, output reset_needed, output stalled_chip,
                    output chip_died, input ready);
    modport sink   (input valid, input reset_needed, input stalled_chip,
                    input chip_died, output ready);
endinterface

@@ hw/rtl/pcsw_ram.sv @@
module pcsw_ram #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/pcsw_div.sv @@
module pcsw_div import pcsw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [ENG_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_dvd;
    logic [ENG_W-1:0]  r_dsr;
    logic [ENG_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ENG_W:0] rem_sh;
    logic           q_bit;
    logic [ENG_W:0] rem_sub;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DIVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        q_bit   = (rem_sh >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[ENG_W-1:0] : rem_sh[ENG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

@@ hw/rtl/per_chip_stall_watchdog.sv @@
// Per-chip stall watchdog for a multi-chip hashing board.
// Input channel i_req carries one transaction per event: a result report
// (cmd 0) records engine count and time for one chip; a health check
// (cmd 1) either pushes the stored times forward (idle) or walks the
// enabled chips and flags the first one whose results have stalled.
// Output channel o_rsp returns exactly one transaction per event.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while no event is in flight, which the block does not enforce.
// A result report passes through the read, evaluate and done steps before it
// reaches the output register. A check spends a single scan step on each skipped
// (disabled) chip and scan, read and evaluate steps on each examined chip, plus,
// for each chip whose timeout has to be worked out, a wait on the 11-step serial
// divider that forms floor(timeout*32/engines) and a compare step. One event is
// processed at a time; the per-chip record lives in one RAM, read then
// written back.
// Reset (synchronous, active low) restores the default configuration and
// marks every RAM entry invalid, so unwritten chips read as all zero.
// A finished transaction waits in the output register; the next event is
// accepted meanwhile, and a stalled receiver holds only the final step.
module per_chip_stall_watchdog import pcsw_pkg::*; #(
    parameter int NUM_CHIPS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcsw_req_if.sink              i_req,
    pcsw_rsp_if.source            o_rsp
);
    localparam int AW = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
    localparam int CW = $clog2(NUM_CHIPS + 1);
    localparam int RW = $bits(t_rec);

    // configuration
    logic               r_long;
    logic [COUNT_W-1:0] r_count;
    logic [MASK_W-1:0]  r_mask;

    // sequencer
    t_state r_state, n_state;

    // event held for the duration of its processing
    logic              r_cmd;
    logic              r_idle;
    logic [ENG_W-1:0]  r_eng;
    logic [TIME_W-1:0] r_now;
    logic [CW-1:0]     r_idx;
    t_rec              r_ent;
    t_rsp              r_res;

    // entry valid bits, cleared at reset
    logic [NUM_CHIPS-1:0] r_vld;
    logic                 r_rd_vld;

    // output register
    logic r_out_vld;
    t_rsp r_out;

    logic [RW-1:0]     ram_rdata;
    logic              ram_we;
    t_rec              wrec;
    logic              idx_inc;
    logic              div_start;
    logic              res_set;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    logic          accept;
    logic          out_free;
    logic [4:0]    count5;
    logic [CW-1:0] lim;
    logic [4:0]    chip5;
    logic [CW-1:0] chip_clamped;
    logic [4:0]    idx5;
    logic          enabled;
    logic          at_end;
    t_rec          ent;
    logic          candidate;
    logic [TIME_W:0]     limit33;
    logic                stalled;
    logic [STREAK_W-1:0] streak_up;
    logic                died;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_vld || o_rsp.ready;

    // walk limit and chip index clamps
    always_comb begin
        count5       = {1'b0, r_count};
        lim          = (count5 > 5'(NUM_CHIPS)) ? CW'(NUM_CHIPS) : CW'(count5);
        chip5        = {1'b0, i_req.chip};
        chip_clamped = (chip5 >= 5'(NUM_CHIPS)) ? CW'(NUM_CHIPS - 1) : CW'(chip5);
        idx5         = 5'(r_idx);
        enabled      = (idx5 < 5'(ENABLE_CHIPS)) && r_mask[idx5[2:0]];
        at_end       = (r_idx == lim);
    end

    // entry as read, with never-written entries seen as zero
    always_comb begin
        ent       = r_rd_vld ? t_rec'(ram_rdata) : '0;
        candidate = !ent.dead && (ent.streak < MAX_STREAK) && ent.seen
                    && (ent.eng != '0);
        limit33   = {1'b0, r_ent.stamp} + (TIME_W + 1)'(div_q);
        stalled   = limit33 < {1'b0, r_now};
        streak_up = r_ent.streak + 1'b1;
        died      = (streak_up == MAX_STREAK);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.cmd == CMD_CHECK) ? S_SCAN : S_READ;
                end
            end
            S_SCAN: begin
                if (at_end) begin
                    n_state = S_DONE;
                end else if (!r_idle && !enabled) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (r_cmd == CMD_REPORT) begin
                    n_state = S_DONE;
                end else if (r_idle) begin
                    n_state = S_SCAN;
                end else if (candidate) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = stalled ? S_DONE : S_SCAN;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        ram_we    = 1'b0;
        wrec      = ent;
        idx_inc   = 1'b0;
        div_start = 1'b0;
        res_set   = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                idx_inc = !at_end && !r_idle && !enabled;
            end
            S_EVAL: begin
                if (r_cmd == CMD_REPORT) begin
                    // result report: record engines and time
                    ram_we     = 1'b1;
                    wrec.stamp = r_now;
                    wrec.eng   = r_eng;
                    wrec.seen  = 1'b1;
                end else if (r_idle) begin
                    // idle push of nonzero times
                    ram_we     = (ent.stamp != '0);
                    wrec.stamp = r_now + IDLE_GRACE;
                    idx_inc    = 1'b1;
                end else if (candidate) begin
                    div_start = 1'b1;
                end else begin
                    ram_we      = 1'b1;
                    wrec.streak = '0;
                    idx_inc     = 1'b1;
                end
            end
            S_CMP: begin
                wrec   = r_ent;
                ram_we = 1'b1;
                if (stalled) begin
                    wrec.streak = streak_up;
                    wrec.stamp  = r_now;
                    if (died) begin
                        wrec.dead = 1'b1;
                        wrec.eng  = '0;
                    end
                    res_set = 1'b1;
                end else begin
                    wrec.streak = '0;
                    idx_inc     = 1'b1;
                end
            end
            S_IDLE, S_READ, S_DIV, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    pcsw_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_CHIPS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (wrec),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    pcsw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_long ? LONG_LIMIT : SHORT_LIMIT),
        .i_divisor  (ent.eng),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_long    <= 1'b0;
            r_count   <= RESET_CHIP_COUNT;
            r_mask    <= RESET_MASK;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_vld[r_idx[AW-1:0]] <= 1'b1;
            end
            // hold the result until taken
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_TIMEOUT: r_long  <= i_cfg_data[0];
                    CFG_CHIP_COUNT:   r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_ENABLE_MASK:  r_mask  <= i_cfg_data[MASK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_vld <= (r_idx < CW'(NUM_CHIPS)) && r_vld[r_idx[AW-1:0]];
        if (accept) begin
            r_cmd  <= i_req.cmd;
            r_idle <= i_req.idle;
            r_eng  <= i_req.engines;
            r_now  <= i_req.now;
            r_idx  <= (i_req.cmd == CMD_CHECK) ? '0 : chip_clamped;
            r_res  <= '0;
        end else begin
            if (idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (res_set) begin
                r_res <= '{reset_needed: 1'b1, stalled_chip: idx5[2:0], chip_died: died};
            end
        end
        if (r_state == S_EVAL) begin
            r_ent <= ent;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.reset_needed = r_out.reset_needed;
    assign o_rsp.stalled_chip = r_out.stalled_chip;
    assign o_rsp.chip_died    = r_out.chip_died;
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb import pcsw_pkg::*; ;

    localparam int          CHIPS        = 8;
    localparam int          PHASES       = 8;
    localparam int          PHASE_EVENTS = 90;
    localparam int          LONG_HOLD    = 300;
    // Worst-case walk over every chip, plus margin for the handshake.
    localparam int          SETTLE       = 16 * CHIPS + 10;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic              cmd;
        logic [CHIP_W-1:0] chip;
        logic [ENG_W-1:0]  eng;
        logic [TIME_W-1:0] now;
        logic              idle;
    } t_watch_event;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pcsw_req_if req ();
    pcsw_rsp_if rsp ();

    per_chip_stall_watchdog #(
        .NUM_CHIPS(CHIPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    // Shadow copy of the per-chip records and of the configuration
    t_rec              chip_rec [CHIPS];
    logic              cfg_long  = 1'b0;
    logic [COUNT_W-1:0] cfg_count = RESET_CHIP_COUNT;
    logic [MASK_W-1:0] cfg_mask  = RESET_MASK;

    t_watch_event      pending_events [$];
    t_rsp              expected_verdicts [$];

    int unsigned       fault_count  = 0;
    int unsigned       cycle_count  = 0;
    int unsigned       holds_asked  = 0;
    int unsigned       holds_served = 0;
    int unsigned       hold_left    = 0;
    int unsigned       ready_gap    = 0;
    int unsigned       send_gap     = 0;
    bit                last_stretch = 1'b0;
    logic [TIME_W-1:0] wall_now     = 32'd1000;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Work out the verdict of one event and advance the shadow records.
    function automatic t_rsp judge_event(input t_watch_event ev);
        t_rsp        verdict;
        int          slot;
        int          walk;
        int unsigned budget;
        logic [TIME_W:0] deadline;
        verdict = '0;
        if (ev.cmd == CMD_REPORT) begin
            // Out-of-range reporters fold onto the last chip
            slot = (ev.chip >= CHIPS) ? CHIPS - 1 : int'(ev.chip);
            chip_rec[slot].eng   = ev.eng;
            chip_rec[slot].stamp = ev.now;
            chip_rec[slot].seen  = 1'b1;
            return verdict;
        end
        walk = (cfg_count > CHIPS) ? CHIPS : int'(cfg_count);
        if (ev.idle) begin
            // Idle check: push every recorded time within the walk forward, wrapping at 32 bits
            for (int i = 0; i < walk; i++)
                if (chip_rec[i].stamp != '0)
                    chip_rec[i].stamp = ev.now + IDLE_GRACE;
            return verdict;
        end
        for (int i = 0; i < walk; i++) begin
            if (i < ENABLE_CHIPS && cfg_mask[i]) begin
                if (!chip_rec[i].dead && chip_rec[i].streak < MAX_STREAK &&
                    chip_rec[i].seen && chip_rec[i].eng != '0) begin
                    budget   = (cfg_long ? LONG_LIMIT : SHORT_LIMIT) / chip_rec[i].eng;
                    deadline = {1'b0, chip_rec[i].stamp} + (TIME_W + 1)'(budget);
                    if (deadline < {1'b0, ev.now}) begin
                        chip_rec[i].streak = chip_rec[i].streak + 1'b1;
                        chip_rec[i].stamp  = ev.now;
                        verdict.reset_needed = 1'b1;
                        verdict.stalled_chip = OUT_CHIP_W'(i);
                        if (chip_rec[i].streak == MAX_STREAK) begin
                            chip_rec[i].dead = 1'b1;
                            chip_rec[i].eng  = '0;
                            verdict.chip_died = 1'b1;
                        end
                        return verdict;
                    end
                end
                // Passed over without a trigger: the streak is broken
                chip_rec[i].streak = '0;
            end
        end
        return verdict;
    endfunction

    function automatic t_watch_event make_event(input logic cmd, input int chip, input int eng,
                                                input logic [TIME_W-1:0] now, input logic idle);
        t_watch_event ev;
        ev.cmd  = cmd;
        ev.chip = CHIP_W'(chip);
        ev.eng  = ENG_W'(eng);
        ev.now  = now;
        ev.idle = idle;
        return ev;
    endfunction

    // Random event on a running wall clock; mostly reports and checks, some noise.
    function automatic t_watch_event random_event();
        t_watch_event ev;
        int unsigned  roll;
        int unsigned  eng_roll;
        roll = $urandom_range(0, 99);
        wall_now = wall_now + (($urandom_range(0, 9) < 7) ? $urandom_range(0, 30)
                                                          : $urandom_range(31, 700));
        ev.cmd  = 1'($urandom);
        ev.chip = CHIP_W'($urandom);
        ev.eng  = ENG_W'($urandom);
        ev.now  = wall_now;
        ev.idle = 1'($urandom);
        if (roll < 8) begin
            // Noise: every field free, time anywhere in the 32-bit range
            ev.now = $urandom();
        end else if (roll < 50) begin
            ev.cmd  = CMD_REPORT;
            ev.chip = ($urandom_range(0, 9) < 8) ? CHIP_W'($urandom_range(0, CHIPS - 1))
                                                 : CHIP_W'($urandom_range(CHIPS, 15));
            eng_roll = $urandom_range(0, 19);
            if (eng_roll == 0)
                ev.eng = '0;
            else if (eng_roll == 1)
                ev.eng = 8'd1;
            else if (eng_roll == 2)
                ev.eng = 8'd255;
            else
                ev.eng = ENG_W'($urandom_range(1, 255));
        end else begin
            ev.cmd  = CMD_CHECK;
            ev.idle = ($urandom_range(0, 9) == 0);
        end
        return ev;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_LONG_TIMEOUT: cfg_long  = data[0];
            CFG_CHIP_COUNT:   cfg_count = data[COUNT_W-1:0];
            CFG_ENABLE_MASK:  cfg_mask  = data[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers; stray upper data bits must be dropped by the block.
    task automatic apply_settings(input logic lt, input int count, input int mask);
        write_reg(CFG_LONG_TIMEOUT, {7'($urandom), lt});
        write_reg(CFG_CHIP_COUNT, {4'($urandom), 4'(count)});
        write_reg(CFG_ENABLE_MASK, 8'(mask));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every queued event is accepted and every verdict has come back.
    task automatic drain_events();
        while (pending_events.size() != 0 || req.valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sender: offer the next pending event, with random bursts of idling.
    always @(posedge i_clk) begin : event_driver
        t_watch_event ev;
        if (!i_rst_n) begin
            req.valid <= 1'b0;
            send_gap  <= 0;
        end else if (!req.valid || req.ready) begin
            if (send_gap != 0) begin
                req.valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (pending_events.size() == 0) begin
                req.valid <= 1'b0;
            end else if (!last_stretch && $urandom_range(0, 7) == 0) begin
                // Idle this cycle and perhaps longer, as drawn into send_gap
                req.valid <= 1'b0;
                send_gap  <= $urandom_range(0, 2);
            end else begin
                ev = pending_events.pop_front();
                req.valid   <= 1'b1;
                req.cmd     <= ev.cmd;
                req.chip    <= ev.chip;
                req.engines <= ev.eng;
                req.now     <= ev.now;
                req.idle    <= ev.idle;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off when one is asked for.
    always @(posedge i_clk) begin : verdict_sink
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
            ready_gap <= 0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            rsp.ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end else if (ready_gap != 0) begin
            ready_gap <= ready_gap - 1;
            rsp.ready <= 1'b0;
        end else if (!last_stretch && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            ready_gap <= $urandom_range(0, 2);
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    // Predict on every accepted event; compare every accepted verdict in order.
    always @(posedge i_clk) begin : verdict_check
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (req.valid && req.ready)
                expected_verdicts.push_back(judge_event(make_event(req.cmd, req.chip,
                    req.engines, req.now, req.idle)));
            if (rsp.valid && rsp.ready) begin
                got.reset_needed = rsp.reset_needed;
                got.stalled_chip = rsp.stalled_chip;
                got.chip_died    = rsp.chip_died;
                if (expected_verdicts.size() == 0) begin
                    if (fault_count < MAX_REPORTS)
                        $display("cycle %0d: verdict with none outstanding: need %b chip %0d died %b",
                                 cycle_count, got.reset_needed, got.stalled_chip,
                                 got.chip_died);
                    fault_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.reset_needed !== want.reset_needed ||
                        got.stalled_chip !== want.stalled_chip ||
                        got.chip_died !== want.chip_died) begin
                        if (fault_count < MAX_REPORTS)
                            $display("cycle %0d: need %b/%b chip %0d/%0d died %b/%b (exp/act)",
                                     cycle_count, want.reset_needed, got.reset_needed,
                                     want.stalled_chip, got.stalled_chip,
                                     want.chip_died, got.chip_died);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_chip_stall_watchdog regression: fail");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CHIPS; i++)
            chip_rec[i] = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        req.valid   = 1'b0;
        req.cmd     = CMD_REPORT;
        req.chip    = '0;
        req.engines = '0;
        req.now     = '0;
        req.idle    = 1'b0;
        rsp.ready   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed opening under the reset configuration
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'd5, 1'b0));   // nothing seen yet
        pending_events.push_back(make_event(CMD_REPORT, 0, 255, 32'd100, 1'b0));
        pending_events.push_back(make_event(CMD_REPORT, 3, 1, 32'd100, 1'b1));
        pending_events.push_back(make_event(CMD_REPORT, 12, 16, 32'd50, 1'b0)); // folds to chip 7
        pending_events.push_back(make_event(CMD_REPORT, 15, 8, 32'd60, 1'b0));
        pending_events.push_back(make_event(CMD_CHECK, 9, 77, 32'd200, 1'b1)); // idle push
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'd211, 1'b0));  // deadline equals now
        // Drive chip 0 through five resets in a row until it dies
        for (int t = 212; t <= 220; t += 2)
            pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'(t), 1'b0));
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'd221, 1'b0));  // dead chip skipped
        pending_events.push_back(make_event(CMD_REPORT, 1, 0, 32'd0, 1'b0));   // zero engines
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'd700, 1'b0));
        pending_events.push_back(make_event(CMD_REPORT, 2, 255, 32'hFFFF_FFFF, 1'b0));
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'hFFFF_FFFF, 1'b0)); // no wrap
        pending_events.push_back(make_event(CMD_CHECK, 0, 0, 32'hFFFF_FFF8, 1'b1)); // push wraps
        pending_events.push_back(make_event(CMD_REPORT, 5, 170, 32'hAAAA_5555, 1'b1));
        pending_events.push_back(make_event(CMD_REPORT, 6, 85, 32'h5555_AAAA, 1'b0));
        pending_events.push_back(make_event(CMD_CHECK, 15, 255, 32'h0000_1000, 1'b0));
        drain_events();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(1'b0, 8, 8'hFF);
                1: apply_settings(1'b1, 8, 8'hA5);
                2: apply_settings(1'b0, 3, 8'hFF);
                3: apply_settings(1'b1, 15, 8'h5A);   // count beyond the chip total
                4: apply_settings(1'b0, 0, $urandom_range(0, 255));
                5: apply_settings(1'b1, 1, 8'h00);
                6: begin
                    write_reg(CFG_SPARE, 8'($urandom));
                    apply_settings(1'($urandom), $urandom_range(0, 15), $urandom_range(0, 255));
                end
                default: begin
                    // Last stretch: default settings, no idling on either side
                    apply_settings(1'b0, 8, 8'hFF);
                    last_stretch = 1'b1;
                end
            endcase
            // Stall the receiver long enough to back the block up into its input
            if (phase == 1)
                holds_asked++;
            for (int n = 0; n < PHASE_EVENTS; n++)
                pending_events.push_back(random_event());
            drain_events();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (fault_count == 0 && expected_verdicts.size() == 0) begin
            $display("per_chip_stall_watchdog regression: pass");
        end else begin
            $display("per_chip_stall_watchdog regression: fail");
        end
        $finish;
    end

endmodule

@@ per_chip_stall_watchdog.f @@
hw/rtl/pcsw_pkg.sv
hw/rtl/pcsw_req_if.sv
hw/rtl/pcsw_rsp_if.sv
hw/rtl/pcsw_ram.sv
hw/rtl/pcsw_div.sv
hw/rtl/per_chip_stall_watchdog.sv
verif/tb.sv
